FILE: hdl/sfla_pkg.sv
// Shared types and constants for the size-class free-list allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfla_pkg;

    localparam int FIELD_CLASSES = 4;
    localparam int CLS_W         = 2;
    localparam int CNT_W         = 3;
    localparam int SIZE_W        = 12;
    localparam int CAP_W         = 9;
    localparam int ADDR_W        = 20;
    localparam int BYTE_W        = 26;
    localparam int BSUM_W        = 13;
    localparam int PROD_W        = SIZE_W + CAP_W;
    localparam int DIV_K_W       = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 48;
    localparam int CTR_W         = 32;

    localparam logic [CNT_W-1:0]   COUNT_RESET = 3'd4;
    localparam logic [47:0]        SIZES_RESET = 48'd8797166895120;
    localparam logic [35:0]        CAPS_RESET  = 36'd8606744640;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPS  = 2'd2;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;
    localparam logic [1:0] ST_LAYOUT  = 2'd3;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SUM    = 11'b00000000010,
        S_LAY    = 11'b00000000100,
        S_FILL   = 11'b00000001000,
        S_ASCAN  = 11'b00000010000,
        S_APOP   = 11'b00000100000,
        S_AGRANT = 11'b00001000000,
        S_FSCAN  = 11'b00010000000,
        S_FDIV   = 11'b00100000000,
        S_FPUSH  = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic start;
        logic sum_step;
        logic lay_begin;
        logic lay_class;
        logic fill_step;
        logic lay_next;
        logic lay_end;
        logic next_i;
        logic pick;
        logic miss;
        logic fail;
        logic pop;
        logic grant;
        logic div_step;
        logic push;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       cfg_end;
        logic       live_end;
        logic       layout_ok;
        logic       a_hit;
        logic       f_hit;
        logic       fill_end;
        logic       div_end;
        logic       out_free;
    } stat_t;

endpackage

`default_nettype wire

FILE: hdl/size_class_free_list_allocator_top.sv
// Top level of the size-class free-list allocator: controller plus datapath.
// Depends on sfla_pkg, sfla_ctrl, sfla_datapath and sfla_ram.
// Init lays out the link lists one block a cycle.
// One transaction in flight; a finished result waits in the output register while the next
// transaction is taken. Reset clears control, layout and counters; the link RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module size_class_free_list_allocator_top #(
    parameter int CLASS_SLOTS  = 4,
    parameter int TOTAL_BLOCKS = 256,
    parameter int BUFFER_BYTES = 1048576
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [sfla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sfla_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      op,
    input  wire logic [sfla_pkg::SIZE_W-1:0]     request_bytes,
    input  wire logic [sfla_pkg::ADDR_W-1:0]     block_address,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [1:0]                      status,
    output logic      [sfla_pkg::ADDR_W-1:0]     granted_address,
    output logic      [sfla_pkg::CLS_W-1:0]      class_index,
    output logic      [sfla_pkg::CTR_W-1:0]      alloc_count,
    output logic      [sfla_pkg::CTR_W-1:0]      free_count
);

    sfla_pkg::cmd_t  cmd;
    sfla_pkg::stat_t st;

    sfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    sfla_datapath #(
        .CLASS_SLOTS  (CLASS_SLOTS),
        .TOTAL_BLOCKS (TOTAL_BLOCKS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .op              (op),
        .request_bytes   (request_bytes),
        .block_address   (block_address),
        .cmd             (cmd),
        .st              (st),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .granted_address (granted_address),
        .class_index     (class_index),
        .alloc_count     (alloc_count),
        .free_count      (free_count)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("transaction accepted without leaving idle");

    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != sfla_pkg::ST_OK)) |->
        ((granted_address == '0) && (class_index == '0)))
        else $error("failed transaction carries a grant or class");

    a_layout_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == sfla_pkg::ST_LAYOUT)) |->
        ((alloc_count == '0) && (free_count == '0)))
        else $error("failed init left counters set");

endmodule

`default_nettype wire

FILE: hdl/sfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/sfla_ctrl.sv
// Sequencing state machine for init, allocate and free transactions.
// Depends on sfla_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps
`default_nettype none

module sfla_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire sfla_pkg::stat_t st,
    output sfla_pkg::cmd_t      cmd
);

    sfla_pkg::state_t state_reg;
    sfla_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfla_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != sfla_pkg::S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            sfla_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    unique case (st.op)
                        sfla_pkg::OP_INIT:  state_next = sfla_pkg::S_SUM;
                        sfla_pkg::OP_ALLOC: state_next = sfla_pkg::S_ASCAN;
                        sfla_pkg::OP_FREE:  state_next = sfla_pkg::S_FSCAN;
                        default:            state_next = sfla_pkg::S_DONE;
                    endcase
                end
            end
            sfla_pkg::S_SUM:
            begin
                if (!st.cfg_end)
                begin
                    cmd.sum_step = 1'b1;
                end
                else if (st.layout_ok)
                begin
                    cmd.lay_begin = 1'b1;
                    state_next    = sfla_pkg::S_LAY;
                end
                else
                begin
                    cmd.fail   = 1'b1;
                    state_next = sfla_pkg::S_DONE;
                end
            end
            sfla_pkg::S_LAY:
            begin
                if (st.cfg_end)
                begin
                    cmd.lay_end = 1'b1;
                    state_next  = sfla_pkg::S_DONE;
                end
                else
                begin
                    cmd.lay_class = 1'b1;
                    state_next    = sfla_pkg::S_FILL;
                end
            end
            sfla_pkg::S_FILL:
            begin
                if (st.fill_end)
                begin
                    cmd.lay_next = 1'b1;
                    state_next   = sfla_pkg::S_LAY;
                end
                else
                begin
                    cmd.fill_step = 1'b1;
                end
            end
            sfla_pkg::S_ASCAN:
            begin
                priority if (st.live_end)
                begin
                    cmd.miss   = 1'b1;
                    state_next = sfla_pkg::S_DONE;
                end
                else if (st.a_hit)
                begin
                    cmd.pick   = 1'b1;
                    state_next = sfla_pkg::S_APOP;
                end
                else
                begin
                    cmd.next_i = 1'b1;
                end
            end
            sfla_pkg::S_APOP:
            begin
                cmd.pop    = 1'b1;
                state_next = sfla_pkg::S_AGRANT;
            end
            sfla_pkg::S_AGRANT:
            begin
                cmd.grant  = 1'b1;
                state_next = sfla_pkg::S_DONE;
            end
            sfla_pkg::S_FSCAN:
            begin
                priority if (st.live_end)
                begin
                    cmd.miss   = 1'b1;
                    state_next = sfla_pkg::S_DONE;
                end
                else if (st.f_hit)
                begin
                    cmd.pick   = 1'b1;
                    state_next = sfla_pkg::S_FDIV;
                end
                else
                begin
                    cmd.next_i = 1'b1;
                end
            end
            sfla_pkg::S_FDIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_end)
                begin
                    state_next = sfla_pkg::S_FPUSH;
                end
            end
            sfla_pkg::S_FPUSH:
            begin
                cmd.push   = 1'b1;
                state_next = sfla_pkg::S_DONE;
            end
            sfla_pkg::S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sfla_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sfla_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/sfla_datapath.sv
// Layout registers, list heads, link RAM, divider and result register.
// Depends on sfla_pkg and sfla_ram; steered by sfla_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module sfla_datapath #(
    parameter int CLASS_SLOTS  = 4,
    parameter int TOTAL_BLOCKS = 256,
    parameter int BUFFER_BYTES = 1048576
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [sfla_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sfla_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [1:0]                          op,
    input  wire logic [sfla_pkg::SIZE_W-1:0]         request_bytes,
    input  wire logic [sfla_pkg::ADDR_W-1:0]         block_address,
    input  wire sfla_pkg::cmd_t                      cmd,
    output sfla_pkg::stat_t                          st,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [1:0]                          status,
    output logic      [sfla_pkg::ADDR_W-1:0]         granted_address,
    output logic      [sfla_pkg::CLS_W-1:0]          class_index,
    output logic      [sfla_pkg::CTR_W-1:0]          alloc_count,
    output logic      [sfla_pkg::CTR_W-1:0]          free_count
);

    localparam int BW  = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
    localparam int HW  = BW + 1;
    localparam int LIM = (CLASS_SLOTS < sfla_pkg::FIELD_CLASSES) ?
                         CLASS_SLOTS : sfla_pkg::FIELD_CLASSES;
    localparam logic [sfla_pkg::CNT_W-1:0]  LIM_N   = sfla_pkg::CNT_W'(LIM);
    localparam logic [HW-1:0]               NIL     = '1;
    localparam logic [sfla_pkg::BSUM_W:0]   TOT_LIM = (sfla_pkg::BSUM_W + 1)'(TOTAL_BLOCKS);
    localparam logic [sfla_pkg::BYTE_W-1:0] BUF_LIM = sfla_pkg::BYTE_W'(BUFFER_BYTES);

    logic [sfla_pkg::CNT_W-1:0]  class_count_reg;
    logic [47:0]                 class_sizes_reg;
    logic [35:0]                 class_caps_reg;

    logic [1:0]                  op_reg;
    logic [sfla_pkg::SIZE_W-1:0] req_reg;
    logic [sfla_pkg::ADDR_W-1:0] addr_reg;

    logic [sfla_pkg::CNT_W-1:0]  n_live_reg;
    logic [sfla_pkg::SIZE_W-1:0] size_reg  [sfla_pkg::FIELD_CLASSES];
    logic [sfla_pkg::BYTE_W-1:0] start_reg [sfla_pkg::FIELD_CLASSES];
    logic [sfla_pkg::BYTE_W-1:0] end_reg   [sfla_pkg::FIELD_CLASSES];
    logic [HW-1:0]               first_reg [sfla_pkg::FIELD_CLASSES];
    logic [HW-1:0]               head_reg  [sfla_pkg::FIELD_CLASSES];

    logic [sfla_pkg::CNT_W-1:0]  i_reg;
    logic [sfla_pkg::CAP_W-1:0]  j_reg;
    logic [sfla_pkg::BSUM_W-1:0] blk_sum_reg;
    logic [sfla_pkg::BYTE_W-1:0] byte_sum_reg;
    logic [sfla_pkg::CLS_W-1:0]  sel_reg;
    logic [sfla_pkg::PROD_W-1:0] prod_reg;
    logic [sfla_pkg::BYTE_W-1:0] rem_reg;
    logic [sfla_pkg::CAP_W-1:0]  q_reg;
    logic [sfla_pkg::DIV_K_W-1:0] k_reg;

    logic [sfla_pkg::CTR_W-1:0]  allocs_reg;
    logic [sfla_pkg::CTR_W-1:0]  frees_reg;
    logic [1:0]                  res_status_reg;
    logic [sfla_pkg::ADDR_W-1:0] res_granted_reg;
    logic [sfla_pkg::CLS_W-1:0]  res_cls_reg;

    logic                        out_valid_reg;
    logic [1:0]                  out_status_reg;
    logic [sfla_pkg::ADDR_W-1:0] out_granted_reg;
    logic [sfla_pkg::CLS_W-1:0]  out_cls_reg;
    logic [sfla_pkg::CTR_W-1:0]  out_allocs_reg;
    logic [sfla_pkg::CTR_W-1:0]  out_frees_reg;

    logic [sfla_pkg::CNT_W-1:0]  eff_n;
    logic [sfla_pkg::CLS_W-1:0]  ii;
    logic [sfla_pkg::SIZE_W-1:0] cfg_size;
    logic [sfla_pkg::CAP_W-1:0]  cfg_cap;
    logic [sfla_pkg::PROD_W-1:0] cfg_prod;
    logic [sfla_pkg::BYTE_W-1:0] addr_ext;
    logic [sfla_pkg::BSUM_W-1:0] fill_idx;
    logic [HW-1:0]               off;
    logic [sfla_pkg::BYTE_W-1:0] div_sub;
    logic [HW-1:0]               push_idx;

    logic                        ram_we;
    logic [BW-1:0]               ram_waddr;
    logic [HW-1:0]               ram_wdata;
    logic [BW-1:0]               ram_raddr;
    logic [HW-1:0]               ram_rdata;

    assign eff_n    = (class_count_reg > LIM_N) ? LIM_N : class_count_reg;
    assign ii       = i_reg[sfla_pkg::CLS_W-1:0];
    assign cfg_size = class_sizes_reg[ii*sfla_pkg::SIZE_W +: sfla_pkg::SIZE_W];
    assign cfg_cap  = class_caps_reg[ii*sfla_pkg::CAP_W +: sfla_pkg::CAP_W];
    assign cfg_prod = sfla_pkg::PROD_W'(cfg_size) * sfla_pkg::PROD_W'(cfg_cap);
    assign addr_ext = sfla_pkg::BYTE_W'(addr_reg);
    assign fill_idx = blk_sum_reg + sfla_pkg::BSUM_W'(j_reg);
    assign off      = head_reg[sel_reg] - first_reg[sel_reg];
    assign div_sub  = sfla_pkg::BYTE_W'(size_reg[sel_reg]) << k_reg;
    assign push_idx = first_reg[sel_reg] + HW'(q_reg);

    assign st.op        = op;
    assign st.cfg_end   = (i_reg == eff_n);
    assign st.live_end  = (i_reg == n_live_reg);
    assign st.layout_ok = ({1'b0, blk_sum_reg} <= TOT_LIM) && (byte_sum_reg <= BUF_LIM);
    assign st.a_hit     = (size_reg[ii] >= req_reg) && (head_reg[ii] != NIL);
    assign st.f_hit     = (addr_ext >= start_reg[ii]) && (addr_ext < end_reg[ii]) &&
                          (size_reg[ii] != '0);
    assign st.fill_end  = (j_reg == cfg_cap);
    assign st.div_end   = (k_reg == '0);
    assign st.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        ram_we    = cmd.fill_step || cmd.push;
        ram_waddr = cmd.push ? push_idx[BW-1:0] : fill_idx[BW-1:0];
        ram_wdata = cmd.push ? head_reg[sel_reg] :
                    ((j_reg == '0) ? NIL : HW'(fill_idx - 1'b1));
        ram_raddr = head_reg[sel_reg][BW-1:0];
    end

    sfla_ram #(
        .WIDTH (HW),
        .DEPTH (TOTAL_BLOCKS)
    ) u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= sfla_pkg::COUNT_RESET;
            class_sizes_reg <= sfla_pkg::SIZES_RESET;
            class_caps_reg  <= sfla_pkg::CAPS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sfla_pkg::REG_COUNT: class_count_reg <= cfg_data[sfla_pkg::CNT_W-1:0];
                sfla_pkg::REG_SIZES: class_sizes_reg <= cfg_data[47:0];
                sfla_pkg::REG_CAPS:  class_caps_reg  <= cfg_data[35:0];
                default:             class_count_reg <= class_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_live_reg <= '0;
            allocs_reg <= '0;
            frees_reg  <= '0;
            for (int c = 0; c < sfla_pkg::FIELD_CLASSES; c++)
            begin
                head_reg[c]  <= NIL;
                size_reg[c]  <= '0;
                start_reg[c] <= '0;
                end_reg[c]   <= '0;
                first_reg[c] <= '0;
            end
        end
        else
        begin
            if (cmd.start && (op == sfla_pkg::OP_INIT))
            begin
                n_live_reg <= '0;
                allocs_reg <= '0;
                frees_reg  <= '0;
                for (int c = 0; c < sfla_pkg::FIELD_CLASSES; c++)
                begin
                    head_reg[c]  <= NIL;
                    size_reg[c]  <= '0;
                    start_reg[c] <= '0;
                    end_reg[c]   <= '0;
                    first_reg[c] <= '0;
                end
            end
            if (cmd.lay_class)
            begin
                size_reg[ii]  <= cfg_size;
                start_reg[ii] <= byte_sum_reg;
                end_reg[ii]   <= byte_sum_reg + sfla_pkg::BYTE_W'(cfg_prod);
                first_reg[ii] <= HW'(blk_sum_reg);
            end
            if (cmd.fill_step)
            begin
                head_reg[ii] <= HW'(fill_idx);
            end
            if (cmd.lay_end)
            begin
                n_live_reg <= eff_n;
            end
            if (cmd.grant)
            begin
                head_reg[sel_reg] <= ram_rdata;
                allocs_reg        <= allocs_reg + 1'b1;
            end
            if (cmd.push)
            begin
                head_reg[sel_reg] <= push_idx;
                frees_reg         <= frees_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
        end
        else if (cmd.start || cmd.lay_begin)
        begin
            i_reg <= '0;
        end
        else if (cmd.sum_step || cmd.lay_next || cmd.next_i)
        begin
            i_reg <= i_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg          <= op;
            req_reg         <= request_bytes;
            addr_reg        <= block_address;
            blk_sum_reg     <= '0;
            byte_sum_reg    <= '0;
            res_status_reg  <= sfla_pkg::ST_OK;
            res_granted_reg <= '0;
            res_cls_reg     <= '0;
        end
        if (cmd.lay_begin)
        begin
            blk_sum_reg  <= '0;
            byte_sum_reg <= '0;
        end
        if (cmd.sum_step || cmd.lay_next)
        begin
            blk_sum_reg  <= blk_sum_reg + sfla_pkg::BSUM_W'(cfg_cap);
            byte_sum_reg <= byte_sum_reg + sfla_pkg::BYTE_W'(cfg_prod);
        end
        if (cmd.lay_class)
        begin
            j_reg <= '0;
        end
        if (cmd.fill_step)
        begin
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.pick)
        begin
            sel_reg <= ii;
            rem_reg <= addr_ext - start_reg[ii];
            q_reg   <= '0;
            k_reg   <= sfla_pkg::DIV_K_W'(sfla_pkg::CAP_W - 1);
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= div_sub)
            begin
                rem_reg        <= rem_reg - div_sub;
                q_reg[k_reg]   <= 1'b1;
            end
            k_reg <= k_reg - 1'b1;
        end
        if (cmd.pop)
        begin
            prod_reg <= sfla_pkg::PROD_W'(off[sfla_pkg::CAP_W-1:0]) *
                        sfla_pkg::PROD_W'(size_reg[sel_reg]);
        end
        if (cmd.grant)
        begin
            res_granted_reg <= sfla_pkg::ADDR_W'(start_reg[sel_reg] +
                                                 sfla_pkg::BYTE_W'(prod_reg));
            res_cls_reg     <= sel_reg;
        end
        if (cmd.push)
        begin
            res_cls_reg <= sel_reg;
        end
        if (cmd.miss)
        begin
            res_status_reg <= (op_reg == sfla_pkg::OP_ALLOC) ? sfla_pkg::ST_NOFIT :
                                                                 sfla_pkg::ST_BADADDR;
        end
        if (cmd.fail)
        begin
            res_status_reg <= sfla_pkg::ST_LAYOUT;
        end
        if (cmd.out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= res_granted_reg;
            out_cls_reg     <= res_cls_reg;
            out_allocs_reg  <= allocs_reg;
            out_frees_reg   <= frees_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign granted_address = out_granted_reg;
    assign class_index     = out_cls_reg;
    assign alloc_count     = out_allocs_reg;
    assign free_count      = out_frees_reg;

endmodule

`default_nettype wire

FILE: dv/sfla_checker.sv
// Checker for the size-class free-list allocator: watches the config port and both channels,
// predicts every result from its own model of the free lists and compares in order.
// Depends on sfla_pkg.
`timescale 1ns / 1ps

module sfla_checker
    import sfla_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            op,
    input  logic [SIZE_W-1:0]     request_bytes,
    input  logic [ADDR_W-1:0]     block_address,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [1:0]            status,
    input  logic [ADDR_W-1:0]     granted_address,
    input  logic [CLS_W-1:0]      class_index,
    input  logic [CTR_W-1:0]      alloc_count,
    input  logic [CTR_W-1:0]      free_count,
    output int                    errors,
    output int                    pending
);

    localparam logic [8:0] LIST_EMPTY = 9'd511;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] granted;
        logic [CLS_W-1:0]  cls;
        logic [CTR_W-1:0]  allocs;
        logic [CTR_W-1:0]  frees;
    } alloc_result_t;

    alloc_result_t     expected_q[$];

    logic [CNT_W-1:0]  count_reg;
    logic [47:0]       sizes_reg;
    logic [35:0]       caps_reg;

    logic [8:0]        heads[FIELD_CLASSES];
    logic [8:0]        links[256];
    logic [ADDR_W-1:0] starts[FIELD_CLASSES];
    logic [8:0]        firsts[FIELD_CLASSES];
    int unsigned       live_size[FIELD_CLASSES];
    int unsigned       live_cap[FIELD_CLASSES];
    int unsigned       live_classes;
    logic [CTR_W-1:0]  allocs_done;
    logic [CTR_W-1:0]  frees_done;

    task automatic clear_layout();
        live_classes = 0;
        for (int i = 0; i < FIELD_CLASSES; i++)
        begin
            heads[i]     = LIST_EMPTY;
            starts[i]    = '0;
            firsts[i]    = '0;
            live_size[i] = 0;
            live_cap[i]  = 0;
        end
    endtask

    task automatic build_lists(output logic [1:0] st);
        int unsigned n, blk, byt, idx;
        int unsigned sz[FIELD_CLASSES];
        int unsigned cp[FIELD_CLASSES];
        n   = 32'(count_reg);
        blk = 0;
        byt = 0;
        st  = ST_OK;
        if (n > FIELD_CLASSES)
            n = FIELD_CLASSES;
        clear_layout();
        allocs_done = '0;
        frees_done  = '0;
        for (int i = 0; i < n; i++)
        begin
            sz[i] = 32'(sizes_reg[12*i +: 12]);
            cp[i] = 32'(caps_reg[9*i +: 9]);
            blk += cp[i];
            byt += sz[i] * cp[i];
        end
        if (blk > 256 || byt > 1048576)
        begin
            st = ST_LAYOUT;
        end
        else
        begin
            blk = 0;
            byt = 0;
            for (int i = 0; i < n; i++)
            begin
                live_size[i] = sz[i];
                live_cap[i]  = cp[i];
                starts[i]    = ADDR_W'(byt);
                firsts[i]    = 9'(blk);
                for (int j = 0; j < cp[i]; j++)
                begin
                    idx        = blk + j;
                    links[idx] = heads[i];
                    heads[i]   = 9'(idx);
                end
                blk += cp[i];
                byt += sz[i] * cp[i];
            end
            live_classes = n;
        end
    endtask

    task automatic predict_result(input logic [1:0] o, input logic [SIZE_W-1:0] req,
                                  input logic [ADDR_W-1:0] addr);
        alloc_result_t r;
        int unsigned   off, rend, idx;
        logic [8:0]    h;
        r = '0;
        if (o == OP_INIT)
        begin
            build_lists(r.status);
        end
        else if (o == OP_ALLOC)
        begin
            r.status = ST_NOFIT;
            for (int i = 0; i < live_classes; i++)
            begin
                h = heads[i];
                if (live_size[i] >= 32'(req) && h != LIST_EMPTY)
                begin
                    off       = 32'(h) - 32'(firsts[i]);
                    heads[i]  = links[h];
                    r.granted = ADDR_W'(32'(starts[i]) + off * live_size[i]);
                    r.cls     = CLS_W'(i);
                    r.status  = ST_OK;
                    allocs_done++;
                    break;
                end
            end
        end
        else if (o == OP_FREE)
        begin
            r.status = ST_BADADDR;
            for (int i = 0; i < live_classes; i++)
            begin
                rend = 32'(starts[i]) + live_cap[i] * live_size[i];
                if (addr >= starts[i] && 32'(addr) < rend && live_size[i] != 0)
                begin
                    idx        = 32'(firsts[i]) +
                                 (32'(addr) - 32'(starts[i])) / live_size[i];
                    links[idx] = heads[i];
                    heads[i]   = 9'(idx);
                    r.cls      = CLS_W'(i);
                    r.status   = ST_OK;
                    frees_done++;
                    break;
                end
            end
        end
        r.allocs = allocs_done;
        r.frees  = frees_done;
        expected_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            count_reg   = COUNT_RESET;
            sizes_reg   = SIZES_RESET;
            caps_reg    = CAPS_RESET;
            clear_layout();
            allocs_done = '0;
            frees_done  = '0;
            expected_q.delete();
            errors      = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_COUNT: count_reg = cfg_data[CNT_W-1:0];
                    REG_SIZES: sizes_reg = cfg_data[47:0];
                    REG_CAPS:  caps_reg  = cfg_data[35:0];
                    default:   ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_result(op, request_bytes, block_address);
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result transaction, status %0d", status);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                    if (granted_address !== want.granted)
                    begin
                        $error("granted_address: expected %0h, got %0h", want.granted,
                               granted_address);
                        errors++;
                    end
                    if (class_index !== want.cls)
                    begin
                        $error("class_index: expected %0d, got %0d", want.cls, class_index);
                        errors++;
                    end
                    if (alloc_count !== want.allocs)
                    begin
                        $error("alloc_count: expected %0d, got %0d", want.allocs, alloc_count);
                        errors++;
                    end
                    if (free_count !== want.frees)
                    begin
                        $error("free_count: expected %0d, got %0d", want.frees, free_count);
                        errors++;
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

FILE: dv/size_class_free_list_allocator_top_tb.sv
// Testbench top for the size-class free-list allocator: clock, reset, stimulus and verdict.
// Depends on sfla_pkg, size_class_free_list_allocator_top and sfla_checker.
`timescale 1ns / 1ps

module size_class_free_list_allocator_top_tb;
    import sfla_pkg::*;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            op = OP_INIT;
    logic [SIZE_W-1:0]     request_bytes = '0;
    logic [ADDR_W-1:0]     block_address = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            status;
    logic [ADDR_W-1:0]     granted_address;
    logic [CLS_W-1:0]      class_index;
    logic [CTR_W-1:0]      alloc_count;
    logic [CTR_W-1:0]      free_count;
    int                    errors;
    int                    pending;
    logic                  in_fire = 1'b0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;

    logic [2:0]            cur_count;
    logic [47:0]           cur_sizes;
    logic [35:0]           cur_caps;

    size_class_free_list_allocator_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .request_bytes(request_bytes), .block_address(block_address),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .granted_address(granted_address), .class_index(class_index),
        .alloc_count(alloc_count), .free_count(free_count)
    );

    sfla_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .request_bytes(request_bytes), .block_address(block_address),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .granted_address(granted_address), .class_index(class_index),
        .alloc_count(alloc_count), .free_count(free_count),
        .errors(errors), .pending(pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        in_fire <= in_valid && !in_stall;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    initial
    begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic send_txn(input logic [1:0] o, input logic [SIZE_W-1:0] req,
                            input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        op            <= o;
        request_bytes <= req;
        block_address <= addr;
        do
            @(negedge clk);
        while (!in_fire);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    function automatic int unsigned layout_span();
        int unsigned n, blk, byt;
        n   = (cur_count > 3'd4) ? 4 : 32'(cur_count);
        blk = 0;
        byt = 0;
        for (int i = 0; i < n; i++)
        begin
            blk += 32'(cur_caps[9*i +: 9]);
            byt += 32'(cur_sizes[12*i +: 12]) * 32'(cur_caps[9*i +: 9]);
        end
        if (blk > 256 || byt > 1048576 || byt == 0)
            return 4096;
        return (byt > 1048560) ? 1048560 : byt;
    endfunction

    function automatic int unsigned largest_size();
        int unsigned m;
        m = 1;
        for (int i = 0; i < 4; i++)
            if (32'(cur_sizes[12*i +: 12]) > m)
                m = 32'(cur_sizes[12*i +: 12]);
        return m;
    endfunction

    task automatic random_txns(input int count);
        int unsigned r, span, top;
        span = layout_span();
        top  = largest_size();
        send_txn(OP_INIT, SIZE_W'($urandom), ADDR_W'($urandom));
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            if (r < 4)
                send_txn(OP_INIT, SIZE_W'($urandom), ADDR_W'($urandom));
            else if (r < 7)
                send_txn(OP_UNKNOWN, SIZE_W'($urandom), ADDR_W'($urandom));
            else if (r < 52)
                send_txn(OP_ALLOC, ($urandom_range(9) == 0) ? SIZE_W'($urandom) :
                                   SIZE_W'($urandom_range(top)),
                         ADDR_W'($urandom));
            else
                send_txn(OP_FREE, SIZE_W'($urandom),
                         ($urandom_range(9) == 0) ? ADDR_W'($urandom) :
                                                    ADDR_W'($urandom_range(span + 8)));
        end
        drain();
    endtask

    initial
    begin
        logic [2:0]  counts[9];
        logic [47:0] sizes[9];
        logic [35:0] caps[9];
        counts = '{3'd4, 3'd1, 3'd7, 3'd3, 3'd0, 3'd4, 3'd4, 3'd2, 3'd4};
        sizes  = '{SIZES_RESET,
                   48'd64,
                   {12'd4095, 12'd4095, 12'd4095, 12'd4095},
                   {12'd0, 12'd48, 12'd16, 12'd0},
                   {12'd8, 12'd8, 12'd8, 12'd8},
                   {12'd32, 12'd32, 12'd32, 12'd32},
                   {12'd5, 12'd3, 12'd2, 12'd1},
                   {12'd0, 12'd0, 12'd4095, 12'd100},
                   48'hFFFF_FFFF_FFFF};
        caps   = '{CAPS_RESET,
                   36'd200,
                   {9'd64, 9'd64, 9'd64, 9'd64},
                   {9'd0, 9'd30, 9'd20, 9'd10},
                   {9'd4, 9'd4, 9'd4, 9'd4},
                   {9'd511, 9'd511, 9'd511, 9'd511},
                   {9'd6, 9'd50, 9'd100, 9'd100},
                   {9'd0, 9'd0, 9'd2, 9'd3},
                   {9'd253, 9'd1, 9'd1, 9'd1}};
        cur_count = COUNT_RESET;
        cur_sizes = SIZES_RESET;
        cur_caps  = CAPS_RESET;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct  = 19;
        recv_stall_pct = 55;
        send_txn(OP_UNKNOWN, 12'hFFF, 20'hFFFFF);
        send_txn(OP_ALLOC, 12'd0, 20'd0);
        send_txn(OP_FREE, 12'd0, 20'd0);
        send_txn(OP_FREE, 12'hFFF, 20'hFFFFF);
        send_txn(OP_INIT, 12'd0, 20'd0);
        send_txn(OP_ALLOC, 12'd0, 20'd0);
        send_txn(OP_ALLOC, 12'd4095, 20'd0);
        send_txn(OP_ALLOC, 12'd16, 20'd0);
        send_txn(OP_FREE, 12'd0, 20'd5);
        send_txn(OP_FREE, 12'd0, 20'd5);
        send_txn(OP_ALLOC, 12'd1, 20'd0);
        send_txn(OP_FREE, 12'd0, 20'hFFFFF);
        send_txn(OP_FREE, 12'd0, 20'd16383);
        send_txn(OP_UNKNOWN, 12'd0, 20'd0);
        send_txn(OP_INIT, 12'd0, 20'd0);
        drain();

        for (int p = 0; p < 9; p++)
        begin
            send_idle_pct  = (p < 3) ? 19 : (p < 6) ? 55 : 0;
            recv_stall_pct = (p < 3) ? 55 : (p < 6) ? 19 : 0;
            if (p > 0)
            begin
                cur_count = counts[p];
                cur_sizes = sizes[p];
                cur_caps  = caps[p];
                write_reg(REG_COUNT, {45'd0, cur_count});
                write_reg(REG_SIZES, cur_sizes);
                write_reg(REG_CAPS, {12'd0, cur_caps});
            end
            if (p == 3)
            begin
                send_txn(OP_INIT, 12'd0, 20'd0);
                send_txn(OP_ALLOC, 12'd0, 20'd0);
                send_txn(OP_FREE, 12'd0, 20'd0);
            end
            random_txns(220);
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
